@@ src/pbw_pkg.sv @@
package pbw_pkg;

  // canvas store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // field widths
  localparam int COORD_W   = 12;
  localparam int DIM_W     = 9;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 4;
  localparam int PIX_W     = CHAN_W * NUM_CHAN;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = (COORD_W - 1) + DIM_W + 1;

  // blend modes
  localparam logic [MODE_W-1:0] MODE_ALPHA   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd2;

  // operations
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_PEEK = 1'b1;

  // weighted sum and divide by 255 through a reciprocal
  localparam int CHAN_MAX    = 255;
  localparam int SUM_W       = 17;
  localparam int RECIP_W     = 18;
  localparam int RECIP_255   = 131587;
  localparam int RECIP_SHIFT = 25;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUO_W       = CHAN_W + 1;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              put;
    pixel_t            src;
  } blend_ctl_t;

  typedef struct packed {
    logic mul_en;
    logic div_en;
  } blend_step_t;

endpackage

@@ src/pbw_ram.sv @@
module pbw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic                                           re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   addr,
  input  logic [WIDTH-1:0]                               wdata,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/pbw_blend.sv @@
module pbw_blend import pbw_pkg::*; (
  input  logic        clk,
  input  blend_step_t step,
  input  blend_ctl_t  ctl,
  input  pixel_t      dst,
  output pixel_t      px,
  output logic        wr
);

  sum_t   v_r   [NUM_CHAN];
  sum_t   v_nxt [NUM_CHAN];
  logic   byp_r, byp_nxt;
  logic   wr1_r, wr1_nxt;
  pixel_t dst_r, src_r;
  pixel_t px_r, px_nxt;
  logic   wr_r;

  chan_t sa, da, wd;

  // stage one: products and weighted sums
  always_comb begin
    sa      = ctl.src[PIX_W-1 -: CHAN_W];
    da      = dst[PIX_W-1 -: CHAN_W];
    wd      = (ctl.mode == MODE_ADD) ? da : (CHAN_W'(CHAN_MAX) - sa);
    byp_nxt = 1'b0;
    wr1_nxt = 1'b0;
    unique case (ctl.mode)
      MODE_ALPHA: begin
        if (sa == CHAN_W'(CHAN_MAX)) begin
          byp_nxt = 1'b1;
          wr1_nxt = 1'b1;
        end else if (sa != '0) begin
          wr1_nxt = 1'b1;
        end
      end
      MODE_REPLACE: begin
        byp_nxt = 1'b1;
        wr1_nxt = 1'b1;
      end
      MODE_ADD: begin
        wr1_nxt = (sa != '0);
      end
      default: begin
        wr1_nxt = 1'b0;
      end
    endcase
    wr1_nxt = wr1_nxt & ctl.put;
    for (int k = 0; k < NUM_CHAN; k++) begin
      v_nxt[k] = SUM_W'(dst[k*CHAN_W +: CHAN_W]) * SUM_W'(wd)
               + SUM_W'(ctl.src[k*CHAN_W +: CHAN_W]) * SUM_W'(sa);
    end
  end

  always_ff @(posedge clk) begin
    if (step.mul_en) begin
      v_r   <= v_nxt;
      byp_r <= byp_nxt;
      wr1_r <= wr1_nxt;
      dst_r <= dst;
      src_r <= ctl.src;
    end
  end

  // stage two: divide by 255, saturate
  logic [PROD_W-1:0] prod [NUM_CHAN];
  logic [QUO_W-1:0]  quo  [NUM_CHAN];
  pixel_t            blended;

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      prod[k] = PROD_W'(v_r[k]) * PROD_W'(RECIP_255);
      quo[k]  = QUO_W'(prod[k] >> RECIP_SHIFT);
      blended[k*CHAN_W +: CHAN_W] = (quo[k] > QUO_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX)
                                                                : quo[k][CHAN_W-1:0];
    end
    if (!wr1_r) begin
      px_nxt = dst_r;
    end else if (byp_r) begin
      px_nxt = src_r;
    end else begin
      px_nxt = blended;
    end
  end

  always_ff @(posedge clk) begin
    if (step.div_en) begin
      px_r <= px_nxt;
      wr_r <= wr1_r;
    end
  end

  assign px = px_r;
  assign wr = wr_r;

endmodule

@@ src/pixel_blend_writer.sv @@
// channel   direction  handshake          payload
// in        sink       in_valid/in_stall  operation, x/y coords, source rgba
// out       source     out_valid/out_stall pixel rgba, in_bounds, was_written
// cfg       sink       cfg_write_en       cfg_index, cfg_wdata
//
// one item is in flight at a time: each item passes store read, product
// stage, divide stage and write-back in turn; write-back loads the result
// after reset the store is swept to zero, all STORE_DEPTH words (65536 at
// 256x256), with in_stall high; config writes are taken throughout
// a result sits in the output register while the next item runs; the item
// waits at write-back only if that register is still stalled
module pixel_blend_writer import pbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [COORD_W-1:0]   in_x_coord,
  input  logic [COORD_W-1:0]   in_y_coord,
  input  logic [CHAN_W-1:0]    in_src_red,
  input  logic [CHAN_W-1:0]    in_src_green,
  input  logic [CHAN_W-1:0]    in_src_blue,
  input  logic [CHAN_W-1:0]    in_src_alpha,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAN_W-1:0]    out_pixel_red,
  output logic [CHAN_W-1:0]    out_pixel_green,
  output logic [CHAN_W-1:0]    out_pixel_blue,
  output logic [CHAN_W-1:0]    out_pixel_alpha,
  output logic                 out_in_bounds,
  output logic                 out_was_written,
  // configuration
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;

  logic [2:0] st_r, st_nxt;

  // configuration registers
  logic [MODE_W-1:0] mode_r;
  logic [DIM_W-1:0]  width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ALPHA;
      width_r  <= DIM_W'(256);
      height_r <= DIM_W'(256);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_BLEND_MODE:    mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_CANVAS_WIDTH:  width_r  <= cfg_wdata;
        REG_CANVAS_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // effective canvas, clamped to the store size
  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (int'(width_r)  > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : width_r;
  assign h_eff = (int'(height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_r;

  // bounds check and word address from the incoming coordinates
  logic [COORD_W-2:0] x_mag, y_mag;
  logic               inb;
  logic [IDX_W-1:0]   idx_full;

  assign x_mag = in_x_coord[COORD_W-2:0];
  assign y_mag = in_y_coord[COORD_W-2:0];
  assign inb   = !in_x_coord[COORD_W-1] && !in_y_coord[COORD_W-1]
              && (COORD_W'(x_mag) < COORD_W'(w_eff))
              && (COORD_W'(y_mag) < COORD_W'(h_eff));
  assign idx_full = IDX_W'(y_mag) * IDX_W'(w_eff) + IDX_W'(x_mag);

  // handshake
  logic in_xfer, wb_go;
  assign in_stall = (st_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign wb_go    = (st_r == ST_WB) && (!out_valid || !out_stall);

  // item held for the duration of its read-modify-write
  logic [ADDR_W-1:0] addr_r;
  logic              inb_r;
  blend_ctl_t        ctl_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      addr_r     <= ADDR_W'(idx_full);
      inb_r      <= inb;
      ctl_r.mode <= mode_r;
      ctl_r.put  <= inb && (in_operation == OP_PUT);
      ctl_r.src  <= {in_src_alpha, in_src_blue, in_src_green, in_src_red};
    end
  end

  // clearing sweep after reset
  logic [ADDR_W-1:0] clr_r;
  logic              clr_last;
  assign clr_last = (clr_r == ADDR_W'(STORE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (st_r == ST_CLEAR) begin
      clr_r <= clr_r + ADDR_W'(1);
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_last) st_nxt = ST_IDLE;
      ST_IDLE:  if (in_xfer)  st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_DIV;
      ST_DIV:   st_nxt = ST_WB;
      ST_WB:    if (wb_go)    st_nxt = ST_IDLE;
      default:  st_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  // canvas store: one port, shared by the sweep, the read and the write-back
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  pixel_t            ram_wdata, ram_rdata;
  pixel_t            px;
  logic              px_wr;

  always_comb begin
    ram_re    = in_xfer;
    ram_we    = 1'b0;
    ram_wdata = px;
    ram_addr  = addr_r;
    priority if (st_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
      ram_addr  = clr_r;
    end else if (in_xfer) begin
      ram_addr = ADDR_W'(idx_full);
    end else if (wb_go) begin
      ram_we = px_wr;
    end else begin
      ram_we = 1'b0;
    end
  end

  pbw_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // blend datapath: products on the read cycle, divide on the next
  blend_step_t step;
  assign step.mul_en = (st_r == ST_READ);
  assign step.div_en = (st_r == ST_DIV);

  pbw_blend u_blend (
    .clk  (clk),
    .step (step),
    .ctl  (ctl_r),
    .dst  (ram_rdata),
    .px   (px),
    .wr   (px_wr)
  );

  // output register
  logic   out_valid_r;
  pixel_t out_px_r;
  logic   out_inb_r, out_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_px_r  <= inb_r ? px : '0;   // off canvas reads as zero
      out_inb_r <= inb_r;
      out_wr_r  <= px_wr;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_red   = out_px_r[0*CHAN_W +: CHAN_W];
  assign out_pixel_green = out_px_r[1*CHAN_W +: CHAN_W];
  assign out_pixel_blue  = out_px_r[2*CHAN_W +: CHAN_W];
  assign out_pixel_alpha = out_px_r[3*CHAN_W +: CHAN_W];
  assign out_in_bounds   = out_inb_r;
  assign out_was_written = out_wr_r;

endmodule

@@ src/pbw_checker.sv @@
module pbw_checker import pbw_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [CHAN_W-1:0]    out_pixel_red,
  input logic [CHAN_W-1:0]    out_pixel_green,
  input logic [CHAN_W-1:0]    out_pixel_blue,
  input logic [CHAN_W-1:0]    out_pixel_alpha,
  input logic                 out_in_bounds,
  input logic                 out_was_written
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // off canvas results carry zero and no write
  a_off_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_bounds |-> (out_pixel_red == '0) && (out_pixel_green == '0)
      && (out_pixel_blue == '0) && (out_pixel_alpha == '0) && !out_was_written)
    else $error("off canvas result not zero");

  // the store sweep keeps the input closed right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during store clear");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while busy");

endmodule

bind pixel_blend_writer pbw_checker u_pbw_checker (.*);
